>>> hw/rtl/qrs_pkg.sv
// qrs_pkg: shared types and fixed sizes of the quadratic root solver
// no dependencies
`default_nettype none

package qrs_pkg;

	localparam int ROOT_BITS = 34;
	localparam int KIND_BITS = 2;
	localparam int OUT_BYTES_W = ((2 * ROOT_BITS + 7) / 8) * 8;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_ALL  = 2'd0,
		KIND_NONE = 2'd1,
		KIND_ONE  = 2'd2,
		KIND_TWO  = 2'd3
	} root_kind_t;

endpackage

`default_nettype wire

>>> hw/rtl/qrs_front.sv
// qrs_front: products, discriminant and root classification (two stages)
// depends on qrs_pkg
`default_nettype none

module qrs_front import qrs_pkg::*; #(
	parameter int CB = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic signed [CB-1:0] coef_a,
	input  wire logic signed [CB-1:0] coef_b,
	input  wire logic signed [CB-1:0] coef_c,
	output logic                      out_valid,
	output logic [2*CB:0]             d_mag,
	output root_kind_t                kind,
	output logic                      linear,
	output logic signed [CB-1:0]      a_out,
	output logic signed [CB-1:0]      b_out,
	output logic signed [CB-1:0]      c_out
);

	localparam int D_W = 2 * CB + 2;

	logic                   valid_s1;
	logic signed [CB-1:0]   a_s1, b_s1, c_s1;
	logic signed [2*CB-1:0] bb_s1, ac_s1;

	logic signed [D_W-1:0]  four_ac, d;
	root_kind_t             kind_c;
	logic                   a_zero;
	logic [2*CB:0]          d_mag_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coef_a;
			b_s1  <= coef_b;
			c_s1  <= coef_c;
			bb_s1 <= coef_b * coef_b;
			ac_s1 <= coef_a * coef_c;
		end
	end

	always_comb begin
		four_ac = D_W'(ac_s1) <<< 2;
		d       = D_W'(bb_s1) - four_ac;
		a_zero  = (a_s1 == '0);
		d_mag_c = '0;
		if (a_zero) begin
			if (b_s1 == '0) begin
				kind_c = (c_s1 == '0) ? KIND_ALL : KIND_NONE;
			end else begin
				kind_c = KIND_ONE;
			end
		end else if (d < 0) begin
			kind_c = KIND_NONE;
		end else if (d == '0) begin
			kind_c = KIND_ONE;
		end else begin
			kind_c  = KIND_TWO;
			d_mag_c = d[2*CB:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_mag  <= d_mag_c;
			kind   <= kind_c;
			linear <= a_zero;
			a_out  <= a_s1;
			b_out  <= b_s1;
			c_out  <= c_s1;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/qrs_isqrt.sv
// qrs_isqrt: pipelined restoring integer square root, one root bit per stage
// depends on qrs_pkg
`default_nettype none

module qrs_isqrt import qrs_pkg::*; #(
	parameter int RW   = 33,
	parameter int SB_W = 51
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire logic [2*RW-1:0] x,
	input  wire logic [SB_W-1:0] sb_in,
	output logic                 out_valid,
	output logic [RW-1:0]        root,
	output logic [SB_W-1:0]      sb_out
);

	logic [2*RW-1:0] x_q    [RW];
	logic [RW:0]     rem_q  [RW];
	logic [RW-1:0]   root_q [RW];
	logic [SB_W-1:0] sb_q   [RW];
	logic            v_q    [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [2*RW-1:0] x_i;
		logic [RW:0]     rem_i;
		logic [RW-1:0]   root_i;
		logic [SB_W-1:0] sb_i;
		logic            v_i;
		logic [RW+2:0]   rem_new, trial, diff;
		logic            ge;

		if (k == 0) begin : g_first
			assign x_i    = x;
			assign rem_i  = '0;
			assign root_i = '0;
			assign sb_i   = sb_in;
			assign v_i    = in_valid;
		end else begin : g_next
			assign x_i    = x_q[k-1];
			assign rem_i  = rem_q[k-1];
			assign root_i = root_q[k-1];
			assign sb_i   = sb_q[k-1];
			assign v_i    = v_q[k-1];
		end

		assign rem_new = {rem_i, x_i[2*RW-1 -: 2]};
		assign trial   = {1'b0, root_i, 2'b01};
		assign ge      = (rem_new >= trial);
		assign diff    = rem_new - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_q[k]    <= x_i << 2;
				rem_q[k]  <= ge ? diff[RW:0] : rem_new[RW:0];
				root_q[k] <= {root_i[RW-2:0], ge};
				sb_q[k]   <= sb_i;
			end
		end
	end

	assign out_valid = v_q[RW-1];
	assign root      = root_q[RW-1];
	assign sb_out    = sb_q[RW-1];

endmodule

`default_nettype wire

>>> hw/rtl/qrs_div.sv
// qrs_div: pipelined restoring divider, two numerators over one divisor,
// quotients truncate toward zero (magnitude plus sign); depends on qrs_pkg
`default_nettype none

module qrs_div import qrs_pkg::*; #(
	parameter int NW   = 35,
	parameter int DW   = 17,
	parameter int SB_W = 2
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic signed [NW-1:0] num1,
	input  wire logic signed [NW-1:0] num2,
	input  wire logic signed [DW-1:0] den,
	input  wire logic [SB_W-1:0]      sb_in,
	output logic                      out_valid,
	output logic [NW-1:0]             quo1,
	output logic [NW-1:0]             quo2,
	output logic                      neg1,
	output logic                      neg2,
	output logic [SB_W-1:0]           sb_out
);

	// sign/magnitude split
	logic            v_s1;
	logic [NW-1:0]   n1_s1, n2_s1;
	logic [DW-1:0]   d_s1;
	logic            ng1_s1, ng2_s1;
	logic [SB_W-1:0] sb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n1_s1  <= num1[NW-1] ? NW'(-num1) : num1;
			n2_s1  <= num2[NW-1] ? NW'(-num2) : num2;
			d_s1   <= den[DW-1] ? DW'(-den) : den;
			ng1_s1 <= num1[NW-1] ^ den[DW-1];
			ng2_s1 <= num2[NW-1] ^ den[DW-1];
			sb_s1  <= sb_in;
		end
	end

	logic [NW-1:0]   n1_q [NW];
	logic [NW-1:0]   n2_q [NW];
	logic [DW-1:0]   r1_q [NW];
	logic [DW-1:0]   r2_q [NW];
	logic [DW-1:0]   d_q  [NW];
	logic            ng1_q[NW];
	logic            ng2_q[NW];
	logic [SB_W-1:0] sb_q [NW];
	logic            v_q  [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [NW-1:0]   n1_i, n2_i;
		logic [DW-1:0]   r1_i, r2_i, d_i;
		logic            ng1_i, ng2_i, v_i;
		logic [SB_W-1:0] sb_i;
		logic [DW:0]     t1, t2, s1, s2;
		logic            ge1, ge2;

		if (k == 0) begin : g_first
			assign n1_i  = n1_s1;
			assign n2_i  = n2_s1;
			assign r1_i  = '0;
			assign r2_i  = '0;
			assign d_i   = d_s1;
			assign ng1_i = ng1_s1;
			assign ng2_i = ng2_s1;
			assign sb_i  = sb_s1;
			assign v_i   = v_s1;
		end else begin : g_next
			assign n1_i  = n1_q[k-1];
			assign n2_i  = n2_q[k-1];
			assign r1_i  = r1_q[k-1];
			assign r2_i  = r2_q[k-1];
			assign d_i   = d_q[k-1];
			assign ng1_i = ng1_q[k-1];
			assign ng2_i = ng2_q[k-1];
			assign sb_i  = sb_q[k-1];
			assign v_i   = v_q[k-1];
		end

		assign t1  = {r1_i, n1_i[NW-1]};
		assign t2  = {r2_i, n2_i[NW-1]};
		assign ge1 = (t1 >= {1'b0, d_i});
		assign ge2 = (t2 >= {1'b0, d_i});
		assign s1  = t1 - {1'b0, d_i};
		assign s2  = t2 - {1'b0, d_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_i;
			end
		end

		// quotient bits shift in where numerator bits leave
		always_ff @(posedge clk) begin
			if (en) begin
				n1_q[k]  <= {n1_i[NW-2:0], ge1};
				n2_q[k]  <= {n2_i[NW-2:0], ge2};
				r1_q[k]  <= ge1 ? s1[DW-1:0] : t1[DW-1:0];
				r2_q[k]  <= ge2 ? s2[DW-1:0] : t2[DW-1:0];
				d_q[k]   <= d_i;
				ng1_q[k] <= ng1_i;
				ng2_q[k] <= ng2_i;
				sb_q[k]  <= sb_i;
			end
		end
	end

	assign out_valid = v_q[NW-1];
	assign quo1      = n1_q[NW-1];
	assign quo2      = n2_q[NW-1];
	assign neg1      = ng1_q[NW-1];
	assign neg2      = ng2_q[NW-1];
	assign sb_out    = sb_q[NW-1];

endmodule

`default_nettype wire

>>> hw/rtl/quadratic_root_solver_top.sv
// quadratic_root_solver_top: real roots of a*x^2+b*x+c in signed fixed point
// pipeline stages: 2 front stages, one square root stage per root bit, numerator
// stage, one divider stage per numerator bit plus sign split, output register.
// throughput one item per cycle; the whole pipeline holds while the output
// register is full and m_tready is low
// arst_n clears all valid bits; data registers are not reset
`default_nettype none

module quadratic_root_solver_top import qrs_pkg::*; #(
	parameter int COEF_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    s_tvalid,
	output logic                                         s_tready,
	// coef_a, coef_b, coef_c from bit 0 up, zero padded
	input  wire logic [((3*COEF_BITS+7)/8)*8-1:0]        s_tdata,
	output logic                                         m_tvalid,
	input  wire logic                                    m_tready,
	// upper root, lower root from bit 0 up, zero padded
	output logic [OUT_BYTES_W-1:0]                       m_tdata,
	// root_kind
	output logic [KIND_BITS-1:0]                         m_tuser
);

	localparam int CB    = COEF_BITS;
	localparam int RW    = COEF_BITS + FRAC_BITS + 1;
	localparam int NUM_W = COEF_BITS + FRAC_BITS + 3;
	localparam int DV_W  = COEF_BITS + 1;
	localparam int SQ_SB = KIND_BITS + 1 + 3 * COEF_BITS;
	localparam int EXT_W = ((NUM_W > ROOT_BITS) ? NUM_W : ROOT_BITS) + 1;
	localparam logic [EXT_W-1:0] POS_LIM =
		{{(EXT_W-ROOT_BITS+1){1'b0}}, {(ROOT_BITS-1){1'b1}}};
	localparam logic [EXT_W-1:0] NEG_LIM = POS_LIM + EXT_W'(1);

	logic en;
	logic out_valid_q;
	logic [OUT_BYTES_W-1:0] out_data_q;
	root_kind_t out_kind_q;

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;

	// front end
	logic               f_valid, f_linear;
	logic [2*CB:0]      f_dmag;
	root_kind_t         f_kind;
	logic signed [CB-1:0] f_a, f_b, f_c;

	qrs_front #(.CB(CB)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.coef_a   (s_tdata[CB-1:0]),
		.coef_b   (s_tdata[2*CB-1:CB]),
		.coef_c   (s_tdata[3*CB-1:2*CB]),
		.out_valid(f_valid),
		.d_mag    (f_dmag),
		.kind     (f_kind),
		.linear   (f_linear),
		.a_out    (f_a),
		.b_out    (f_b),
		.c_out    (f_c)
	);

	// square root of d * 2^(2*FRAC_BITS)
	logic [2*RW-1:0]  sq_x;
	logic             sq_valid;
	logic [RW-1:0]    sq_root;
	logic [SQ_SB-1:0] sq_sb;

	assign sq_x = {1'b0, f_dmag, {(2*FRAC_BITS){1'b0}}};

	qrs_isqrt #(.RW(RW), .SB_W(SQ_SB)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (f_valid),
		.x        (sq_x),
		.sb_in    ({f_c, f_b, f_a, f_linear, f_kind}),
		.out_valid(sq_valid),
		.root     (sq_root),
		.sb_out   (sq_sb)
	);

	// numerators and divisor
	root_kind_t            sq_kind;
	logic                  sq_linear;
	logic signed [CB-1:0]  sq_a, sq_b, sq_c;
	logic signed [NUM_W-1:0] nb, ncl, s_ext, num1_c, num2_c;
	logic signed [DV_W-1:0]  den_c;

	assign sq_kind   = root_kind_t'(sq_sb[KIND_BITS-1:0]);
	assign sq_linear = sq_sb[KIND_BITS];
	assign sq_a      = sq_sb[KIND_BITS+1 +: CB];
	assign sq_b      = sq_sb[KIND_BITS+1+CB +: CB];
	assign sq_c      = sq_sb[KIND_BITS+1+2*CB +: CB];

	always_comb begin
		nb    = -(NUM_W'(sq_b) <<< FRAC_BITS);
		ncl   = -(NUM_W'(sq_c) <<< FRAC_BITS);
		s_ext = $signed(NUM_W'(sq_root));
		if (sq_kind == KIND_ALL || sq_kind == KIND_NONE) begin
			num1_c = '0;
			num2_c = '0;
			den_c  = DV_W'(1);
		end else if (sq_linear) begin
			num1_c = ncl;
			num2_c = ncl;
			den_c  = DV_W'(sq_b);
		end else begin
			num1_c = nb + s_ext;
			num2_c = nb - s_ext;
			den_c  = DV_W'(sq_a) <<< 1;
		end
	end

	logic                    v_s3;
	logic signed [NUM_W-1:0] num1_s3, num2_s3;
	logic signed [DV_W-1:0]  den_s3;
	root_kind_t              kind_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num1_s3 <= num1_c;
			num2_s3 <= num2_c;
			den_s3  <= den_c;
			kind_s3 <= sq_kind;
		end
	end

	// division
	logic                 dv_valid, dv_neg1, dv_neg2;
	logic [NUM_W-1:0]     dv_q1, dv_q2;
	logic [KIND_BITS-1:0] dv_sb;

	qrs_div #(.NW(NUM_W), .DW(DV_W), .SB_W(KIND_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.num1     (num1_s3),
		.num2     (num2_s3),
		.den      (den_s3),
		.sb_in    (kind_s3),
		.out_valid(dv_valid),
		.quo1     (dv_q1),
		.quo2     (dv_q2),
		.neg1     (dv_neg1),
		.neg2     (dv_neg2),
		.sb_out   (dv_sb)
	);

	function automatic logic signed [ROOT_BITS-1:0] to_root(
		input logic [NUM_W-1:0] q,
		input logic             neg
	);
		logic [EXT_W-1:0]        qe;
		logic signed [EXT_W-1:0] v;
		qe = EXT_W'(q);
		if (neg) begin
			v = (qe > NEG_LIM) ? -$signed(NEG_LIM) : -$signed(qe);
		end else begin
			v = (qe > POS_LIM) ? $signed(POS_LIM) : $signed(qe);
		end
		return v[ROOT_BITS-1:0];
	endfunction

	root_kind_t                  dv_kind;
	logic signed [ROOT_BITS-1:0] r1, r2, big, sml;

	assign dv_kind = root_kind_t'(dv_sb);

	always_comb begin
		r1 = to_root(dv_q1, dv_neg1);
		r2 = to_root(dv_q2, dv_neg2);
		if (dv_kind == KIND_ALL || dv_kind == KIND_NONE) begin
			big = '0;
			sml = '0;
		end else if (r1 >= r2) begin
			big = r1;
			sml = r2;
		end else begin
			big = r2;
			sml = r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= OUT_BYTES_W'({sml, big});
			out_kind_q <= dv_kind;
		end
	end

endmodule

`default_nettype wire
